/* hdl/running_block_error_estimator_macros.svh */
// assertion macros for the running block error estimator
// no dependencies; included by files that carry concurrent checks
`ifndef RUNNING_BLOCK_ERROR_ESTIMATOR_MACROS_SVH
`define RUNNING_BLOCK_ERROR_ESTIMATOR_MACROS_SVH

`ifndef SYNTHESIS
`define RBEE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define RBEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define RBEE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBEE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/rbee_pkg.sv */
// shared types and constants for the running block error estimator
// no dependencies; imported by every module of the block
package rbee_pkg;

    localparam int MAX_BLOCKS = 65536;
    localparam int CNT_W      = 17;
    localparam int IDX_W      = 16;
    localparam int MEAN_W     = 32;
    localparam int MSQ_W      = 48;
    localparam int VSUM_W     = 48;
    localparam int SSUM_W     = 64;
    localparam int EST_W      = 32;

    // serial divider: two quotient bits per cycle
    localparam int DIV_W      = 64;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // serial squarer: one multiplier bit per cycle
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MUL_CNT_W  = $clog2(MUL_W + 1);

    // serial square root: one root bit per cycle
    localparam int SQ_IN_W    = 64;
    localparam int SQ_OUT_W   = SQ_IN_W / 2;
    localparam int SQ_REM_W   = SQ_OUT_W + 2;
    localparam int SQ_CNT_W   = $clog2(SQ_OUT_W + 1);

    typedef struct packed {
        logic signed [MEAN_W-1:0] block_mean;
        logic [MSQ_W-1:0]         block_mean_square;
        logic                     start_new;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic [EST_W-1:0] error_estimate;
        logic             count_full;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_M,
        ST_DIV_Q,
        ST_MUL,
        ST_VAR,
        ST_DIV_V,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

/* hdl/rbee_div.sv */
// serial restoring divider, 64-bit dividend by 17-bit divisor, two bits per cycle
// depends on rbee_pkg
module rbee_div
    import rbee_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_dvd;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dsr;
    logic [DIV_W-1:0]     n_dvd;
    logic [CNT_W-1:0]     n_rem;

    always_comb begin
        logic [CNT_W:0] w_part;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_part = {n_rem, n_dvd[DIV_W-1]};
            n_dvd  = {n_dvd[DIV_W-2:0], 1'b0};
            if (w_part >= {1'b0, r_dsr}) begin
                n_rem    = CNT_W'(w_part - {1'b0, r_dsr});
                n_dvd[0] = 1'b1;
            end else begin
                n_rem = w_part[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_CYCLES);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

/* hdl/rbee_mul.sv */
// serial shift-add multiplier, 32 by 32 bits, one multiplier bit per cycle
// depends on rbee_pkg
module rbee_mul
    import rbee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_mcand;
    logic [MUL_W-1:0]     r_mplier;
    logic [PROD_W-1:0]    r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= MUL_CNT_W'(MUL_W);
                r_mcand  <= PROD_W'(i_a);
                r_mplier <= i_b;
                r_prod   <= '0;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[MUL_W-1:1]};
                r_cnt    <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

/* hdl/rbee_sqrt.sv */
// serial integer square root, 64-bit radicand, one root bit per cycle
// depends on rbee_pkg
module rbee_sqrt
    import rbee_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_IN_W-1:0]  i_radicand,
    output logic                o_done,
    output logic [SQ_OUT_W-1:0] o_root
);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [SQ_IN_W-1:0]  r_x;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [SQ_REM_W-1:0] n_rem;
    logic [SQ_OUT_W-1:0] n_root;

    always_comb begin
        logic [SQ_REM_W+1:0] w_part;
        logic [SQ_REM_W+1:0] w_trial;
        w_part  = {r_rem, r_x[SQ_IN_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        if (w_part >= w_trial) begin
            n_rem  = SQ_REM_W'(w_part - w_trial);
            n_root = {r_root[SQ_OUT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_part[SQ_REM_W-1:0];
            n_root = {r_root[SQ_OUT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQ_CNT_W'(SQ_OUT_W);
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[SQ_IN_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt - SQ_CNT_W'(1);
                if (r_cnt == SQ_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/running_block_error_estimator.sv */
// for a block count of two or more, the mean and mean-square divisions, a squaring, the variance
// division and a square root run in sequence; the first block of a series skips them all
// the next input transfer is taken once the result is registered, while that result may still
// wait for its output transfer
// reset: synchronous active low, clears sums, block count, state machine and output valid
// depends on rbee_pkg, rbee_div, rbee_mul, rbee_sqrt and the assertion macro header
`include "running_block_error_estimator_macros.svh"

module running_block_error_estimator
    import rbee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_state             r_state;
    t_state             n_state;
    logic [VSUM_W-1:0]  r_val;
    logic [SSUM_W-1:0]  r_sq;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_index;
    logic               r_full;
    logic [MUL_W-1:0]   r_m;
    logic [MSQ_W-1:0]   r_q;
    logic [SSUM_W-1:0]  r_v;
    logic [EST_W-1:0]   r_est;
    logic               r_o_valid;
    t_out_item          r_o_data;

    logic               w_accept;
    logic [VSUM_W-1:0]  w_mag;
    logic [VSUM_W-1:0]  w_base_val;
    logic [SSUM_W-1:0]  w_base_sq;
    logic [CNT_W-1:0]   w_base_count;
    logic               w_is_full;
    logic [CNT_W-1:0]   w_new_count;
    logic [SSUM_W-1:0]  w_hi;
    logic               w_fresh_accept;
    logic               w_full_out;
    logic               w_first_prep;
    logic               w_first_out;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic               mul_start;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [SQ_OUT_W-1:0] sqrt_root;
    logic               load_out;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_base_val   = i_data.start_new ? '0 : r_val;
    assign w_base_sq    = i_data.start_new ? '0 : r_sq;
    assign w_base_count = i_data.start_new ? '0 : r_count;
    assign w_is_full    = (w_base_count >= CNT_W'(MAX_BLOCKS));
    assign w_new_count  = w_is_full ? w_base_count : w_base_count + CNT_W'(1);

    assign w_mag = r_val[VSUM_W-1] ? (~r_val + VSUM_W'(1)) : r_val;
    assign w_hi  = {r_q, 16'h0000};

    assign load_out = (r_state == ST_OUT) && (!r_o_valid || i_ready);

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_count;
        mul_start    = 1'b0;
        sqrt_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_count < CNT_W'(2)) begin
                    n_state = ST_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(w_mag);
                    n_state      = ST_DIV_M;
                end
            end
            ST_DIV_M: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = r_sq;
                    n_state      = ST_DIV_Q;
                end
            end
            ST_DIV_Q: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_VAR;
                end
            end
            ST_VAR: begin
                div_start    = 1'b1;
                div_dividend = r_v;
                div_divisor  = r_count - CNT_W'(1);
                n_state      = ST_DIV_V;
            end
            ST_DIV_V: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    n_state    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // running sums and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val   <= '0;
            r_sq    <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
        end else if (w_accept) begin
            r_full  <= w_is_full;
            r_count <= w_new_count;
            if (w_is_full) begin
                r_val <= w_base_val;
                r_sq  <= w_base_sq;
            end else begin
                r_val <= w_base_val + VSUM_W'(i_data.block_mean);
                r_sq  <= w_base_sq + SSUM_W'(i_data.block_mean_square);
            end
        end
    end

    // intermediate results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_index <= IDX_W'(w_new_count - CNT_W'(1));
        end
        if (r_state == ST_PREP) begin
            r_est <= '0;
        end
        if (r_state == ST_DIV_M && div_done) begin
            r_m <= div_quot[MUL_W-1:0];
        end
        if (r_state == ST_DIV_Q && div_done) begin
            r_q <= div_quot[MSQ_W-1:0];
        end
        if (r_state == ST_MUL && mul_done) begin
            r_v <= (w_hi >= mul_prod) ? (w_hi - mul_prod) : '0;
        end
        if (r_state == ST_SQRT && sqrt_done) begin
            r_est <= sqrt_root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_data.block_index    <= r_index;
            r_o_data.error_estimate <= r_est;
            r_o_data.count_full     <= r_full;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    rbee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    rbee_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_m),
        .i_b       (r_m),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    rbee_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_quot),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign w_fresh_accept = w_accept && i_data.start_new;
    assign w_full_out     = r_full && (r_state == ST_OUT);
    assign w_first_prep   = (r_state == ST_PREP) && (r_count < CNT_W'(2));
    assign w_first_out    = (r_state == ST_OUT) && (r_est == '0);

    `RBEE_ASSERT_NEXT(a_fresh_series, i_clk, i_rst_n, w_fresh_accept, r_count == CNT_W'(1))
    `RBEE_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BLOCKS))
    `RBEE_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, w_full_out, r_count == CNT_W'(MAX_BLOCKS))
    `RBEE_ASSERT_NEXT(a_first_block, i_clk, i_rst_n, w_first_prep, w_first_out)

endmodule
